[rtl/vpcd_pkg.sv]
package vpcd_pkg;

    // Input function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_BLANK = 2'd2;
    localparam logic [1:0] FUNC_PEEK  = 2'd3;

    // Peek spaces
    localparam logic [1:0] SPACE_VRAM  = 2'd0;
    localparam logic [1:0] SPACE_CRAM  = 2'd1;
    localparam logic [1:0] SPACE_VSRAM = 2'd2;
    localparam logic [1:0] SPACE_REGS  = 2'd3;

    // Write target selection, code bits 3:1
    localparam logic [2:0] TGT_VRAM  = 3'd0;
    localparam logic [2:0] TGT_CRAM  = 3'd1;
    localparam logic [2:0] TGT_VSRAM = 3'd2;

    localparam logic [15:0] STATUS_RESET = 16'h3400;

    // Entries in the front-to-back queue
    localparam int unsigned QUEUE_DEPTH = 2;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_NONE,
        OP_DATA,
        OP_CTRL,
        OP_STATUS,
        OP_BLANK,
        OP_PEEK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] value;
        logic [1:0]  space;
        logic [15:0] index;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VLOW,
        ST_FILL,
        ST_RDWAIT,
        ST_OUT
    } state_t;

endpackage

[rtl/video_port_command_decoder.sv]
// Path: each input beat is registered in the front queue, then its result in the
// back end's output register; a VRAM peek adds the ST_RDWAIT state for the read.
// The single-issue back end takes no new item until the result of the last has
// been accepted; an armed fill of n bytes (regs 20:19) writes one byte a cycle
// and holds off the next item until done, as does the low byte of a VRAM pair.
// Reset: rst_n asynchronous, active low; afterwards a clearing pass over all
// 65536 addresses zeroes video RAM, during which at most two beats wait in the queue.
module video_port_command_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] func, [6:2] port_address, [22:7] write_value, [24:23] peek_space,
    // [40:25] peek_index, [47:41] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] read_data
    output logic [15:0] m_tdata
);
    import vpcd_pkg::*;

    logic q_valid, q_ready;
    cmd_t q_cmd;

    vpcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata[40:0]),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    vpcd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[rtl/vpcd_front.sv]
module vpcd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [40:0]          s_tdata,
    output logic                 q_valid,
    input  logic                 q_ready,
    output vpcd_pkg::cmd_t       q_cmd
);
    import vpcd_pkg::*;

    cmd_t        fifo_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    cmd_t        cls;
    logic [1:0]  func;
    logic [4:0]  port;
    logic        push, pop;

    // Classify the beat
    always_comb
    begin
        func      = s_tdata[1:0];
        port      = s_tdata[6:2];
        cls.value = s_tdata[22:7];
        cls.space = s_tdata[24:23];
        cls.index = s_tdata[40:25];
        cls.op    = OP_NONE;
        case (func)
            FUNC_WRITE:
            begin
                if (port < 5'd4)
                    cls.op = OP_DATA;
                else if (port < 5'd8)
                    cls.op = OP_CTRL;
            end
            FUNC_READ:
            begin
                if (port >= 5'd4 && port < 5'd8)
                    cls.op = OP_STATUS;
            end
            FUNC_BLANK: cls.op = OP_BLANK;
            default:    cls.op = OP_PEEK;
        endcase
    end

    assign s_tready = (count_reg != 2'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = fifo_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= cls;
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

[rtl/vpcd_back.sv]
module vpcd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  vpcd_pkg::cmd_t       q_cmd,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata
);
    import vpcd_pkg::*;

    localparam int unsigned VRAM_AW = 16;

    // Stores
    logic [7:0]  vram [2**VRAM_AW];
    logic [15:0] cram [64];
    logic [15:0] vsram [64];
    logic [7:0]  regs_reg [32];
    logic [63:0] cram_vld_reg, vsram_vld_reg;

    // Clearing pass over video RAM after reset
    logic        clr_busy_reg;
    logic [15:0] clr_addr_reg;

    state_t      state_reg, state_next;
    logic [5:0]  code_reg;
    logic [15:0] addr_reg;
    logic        pend_reg, fill_reg;
    logic [15:0] status_reg;
    logic [15:0] fill_cnt_reg;
    logic [7:0]  fill_byte_reg, low_byte_reg;
    logic [15:0] out_reg;
    logic        out_vram_reg;
    logic        out_valid_reg;
    logic [7:0]  vram_rd_reg;

    logic        take;
    logic        vram_we;
    logic [15:0] vram_wa;
    logic [7:0]  vram_wd;
    logic [15:0] fill_len;
    logic [15:0] addr_inc;

    assign fill_len = {regs_reg[20], regs_reg[19]};
    assign addr_inc = addr_reg + {8'd0, regs_reg[15]};
    assign q_ready  = (state_reg == ST_IDLE) && !clr_busy_reg && !out_valid_reg;
    assign take     = q_valid && q_ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_vram_reg ? {8'd0, vram_rd_reg} : out_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (q_cmd.op == OP_DATA && code_reg[0] && code_reg[3:1] == TGT_VRAM)
                        state_next = ST_VLOW;
                    else if (q_cmd.op == OP_DATA && fill_reg && fill_len != 16'd0)
                        state_next = ST_FILL;
                    else if (q_cmd.op == OP_PEEK && q_cmd.space == SPACE_VRAM)
                        state_next = ST_RDWAIT;
                end
            end
            ST_VLOW:   state_next = (fill_reg && fill_len != 16'd0) ? ST_FILL : ST_IDLE;
            ST_FILL:   state_next = (fill_cnt_reg == 16'd1) ? ST_IDLE : ST_FILL;
            ST_RDWAIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Video RAM write port select
    always_comb
    begin
        vram_we = 1'b0;
        vram_wa = addr_reg;
        vram_wd = q_cmd.value[15:8];
        case (state_reg)
            ST_IDLE:
            begin
                if (clr_busy_reg)
                begin
                    vram_we = 1'b1;
                    vram_wa = clr_addr_reg;
                    vram_wd = 8'd0;
                end
                else if (take && q_cmd.op == OP_DATA && code_reg[0]
                         && code_reg[3:1] == TGT_VRAM)
                    vram_we = 1'b1;
            end
            ST_VLOW:
            begin
                vram_we = 1'b1;
                vram_wa = addr_reg;
                vram_wd = low_byte_reg;
            end
            ST_FILL:
            begin
                vram_we = 1'b1;
                vram_wa = addr_reg;
                vram_wd = fill_byte_reg;
            end
            default: vram_we = 1'b0;
        endcase
    end

    // Video RAM; read data held from the accept until the result leaves
    always_ff @(posedge clk)
    begin
        if (vram_we)
            vram[vram_wa] <= vram_wd;
        if (take)
            vram_rd_reg <= vram[q_cmd.index];
    end

    // Small RAMs
    always_ff @(posedge clk)
    begin
        if (take && q_cmd.op == OP_DATA && code_reg[0])
        begin
            if (code_reg[3:1] == TGT_CRAM)
                cram[addr_reg[6:1]] <= q_cmd.value;
            if (code_reg[3:1] == TGT_VSRAM)
                vsram[addr_reg[6:1]] <= q_cmd.value;
        end
    end

    // Control state and sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= 16'd0;
            code_reg      <= 6'd0;
            addr_reg      <= 16'd0;
            pend_reg      <= 1'b0;
            fill_reg      <= 1'b0;
            status_reg    <= STATUS_RESET;
            fill_cnt_reg  <= 16'd0;
            out_valid_reg <= 1'b0;
            out_vram_reg  <= 1'b0;
            cram_vld_reg  <= '0;
            vsram_vld_reg <= '0;
            for (int i = 0; i < 32; i++)
                regs_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 16'd1;
                if (clr_addr_reg == 16'hffff)
                    clr_busy_reg <= 1'b0;
            end
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            // Result is ready once the read settles
            if (state_reg == ST_RDWAIT)
                out_valid_reg <= 1'b1;
            if (take)
            begin
                out_vram_reg <= 1'b0;
                if (!(q_cmd.op == OP_PEEK && q_cmd.space == SPACE_VRAM))
                    out_valid_reg <= 1'b1;
                else
                    out_vram_reg <= 1'b1;
                case (q_cmd.op)
                    OP_DATA:
                    begin
                        if (code_reg[0] && code_reg[3:1] == TGT_CRAM)
                            cram_vld_reg[addr_reg[6:1]] <= 1'b1;
                        if (code_reg[0] && code_reg[3:1] == TGT_VSRAM)
                            vsram_vld_reg[addr_reg[6:1]] <= 1'b1;
                        pend_reg <= 1'b0;
                        fill_cnt_reg <= fill_len;
                        // VRAM pair advances after the low byte; the fill
                        // flag stays up until then
                        if (!(code_reg[0] && code_reg[3:1] == TGT_VRAM))
                        begin
                            addr_reg <= addr_inc;
                            fill_reg <= 1'b0;
                        end
                        else
                            addr_reg <= addr_reg + 16'd1;
                    end
                    OP_CTRL:
                    begin
                        if (!pend_reg)
                        begin
                            if (q_cmd.value[15:14] == 2'b10)
                            begin
                                if (regs_reg[1][2] || q_cmd.value[12:8] <= 5'd10)
                                    regs_reg[q_cmd.value[12:8]] <= q_cmd.value[7:0];
                                code_reg <= 6'd0;
                            end
                            else
                            begin
                                code_reg[1:0] <= q_cmd.value[15:14];
                                addr_reg[13:0] <= q_cmd.value[13:0];
                                pend_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            code_reg[5:2] <= q_cmd.value[7:4];
                            addr_reg[15:14] <= q_cmd.value[1:0];
                            pend_reg <= 1'b0;
                            if (q_cmd.value[7] && regs_reg[1][4]
                                && regs_reg[23][7:6] == 2'b10
                                && !q_cmd.value[4] && code_reg[0]
                                && !code_reg[1])
                                fill_reg <= 1'b1;
                        end
                    end
                    OP_BLANK:
                        status_reg[3:2] <= q_cmd.value[1:0];
                    default: ;
                endcase
            end
            // Low byte of the pair, then step the address
            if (state_reg == ST_VLOW)
            begin
                addr_reg <= addr_reg - 16'd1 + {8'd0, regs_reg[15]};
                fill_cnt_reg <= fill_len;
                fill_reg <= 1'b0;
            end
            if (state_reg == ST_FILL)
            begin
                addr_reg     <= addr_inc;
                fill_cnt_reg <= fill_cnt_reg - 16'd1;
            end
        end
    end

    // Payload captured at the accept
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            low_byte_reg  <= q_cmd.value[7:0];
            fill_byte_reg <= q_cmd.value[15:8];
            case (q_cmd.op)
                OP_STATUS: out_reg <= status_reg;
                OP_PEEK:
                begin
                    case (q_cmd.space)
                        SPACE_CRAM:  out_reg <= cram_vld_reg[q_cmd.index[5:0]]
                                                ? cram[q_cmd.index[5:0]] : 16'd0;
                        SPACE_VSRAM: out_reg <= vsram_vld_reg[q_cmd.index[5:0]]
                                                ? vsram[q_cmd.index[5:0]] : 16'd0;
                        SPACE_REGS:  out_reg <= {8'd0, regs_reg[q_cmd.index[4:0]]};
                        default:     out_reg <= 16'd0;
                    endcase
                end
                default: out_reg <= 16'd0;
            endcase
        end
    end

endmodule

[rtl/vpcd_checker.sv]
module vpcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // No result while in reset
    a_reset: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // Result data known whenever offered
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown(m_tdata))
        else $error("unknown result data");

    // One beat per item: valid drops after each accepted result
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result repeated");

endmodule

bind video_port_command_decoder vpcd_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
